// File: hdl/sgs_pkg.sv
// Shared types and constants for the scan gap segmenter.
package sgs_pkg;

  localparam int DIST_W   = 16;
  localparam int POS_W    = 16;
  localparam int COUNT_W  = 11;
  localparam int LIMIT_W  = 15;
  localparam int OUT_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIST_FLOOR        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OBJECT_POINTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESHOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OBJECTS       = 3'd5;

  localparam logic [DIST_W-1:0]  RST_DIST_FLOOR        = 16'd0;
  localparam logic [COUNT_W-1:0] RST_MIN_OBJECT_POINTS = 11'd1;
  localparam logic [DIST_W-1:0]  RST_GAP_THRESHOLD     = 16'd90;
  localparam logic [LIMIT_W-1:0] RST_X_LIMIT           = 15'd1300;
  localparam logic [LIMIT_W-1:0] RST_Y_LIMIT           = 15'd800;
  localparam logic [COUNT_W-1:0] RST_MAX_OBJECTS       = 11'd16;

  typedef struct packed {
    logic [DIST_W-1:0]  dist_floor;
    logic [COUNT_W-1:0] min_object_points;
    logic [DIST_W-1:0]  gap_threshold;
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
    logic [COUNT_W-1:0] max_objects;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0]        distance;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic                     is_last;
  } point_t;

  typedef struct packed {
    logic             emit;
    logic [OUT_W-1:0] obj_start;
    logic [OUT_W-1:0] obj_len;
  } obj_t;

endpackage

// File: hdl/sgs_cfg.sv
// Configuration register file for the scan gap segmenter.
module sgs_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] wr_data,
  output sgs_pkg::cfg_t                  cfg
);
  import sgs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dist_floor        <= RST_DIST_FLOOR;
      cfg.min_object_points <= RST_MIN_OBJECT_POINTS;
      cfg.gap_threshold     <= RST_GAP_THRESHOLD;
      cfg.x_limit           <= RST_X_LIMIT;
      cfg.y_limit           <= RST_Y_LIMIT;
      cfg.max_objects       <= RST_MAX_OBJECTS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DIST_FLOOR:        cfg.dist_floor        <= wr_data;
        REG_MIN_OBJECT_POINTS: cfg.min_object_points <= wr_data[COUNT_W-1:0];
        REG_GAP_THRESHOLD:     cfg.gap_threshold     <= wr_data;
        REG_X_LIMIT:           cfg.x_limit           <= wr_data[LIMIT_W-1:0];
        REG_Y_LIMIT:           cfg.y_limit           <= wr_data[LIMIT_W-1:0];
        REG_MAX_OBJECTS:       cfg.max_objects       <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/sgs_core.sv
// Per-point segmentation step and scan state.
module sgs_core #(
  parameter int MAX_POINTS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  sgs_pkg::point_t pt,
  input  sgs_pkg::cfg_t   cfg,
  output sgs_pkg::obj_t   res
);
  import sgs_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_POINTS - 1);

  logic [IW-1:0]      point_index;
  logic               tracking;
  logic [IW-1:0]      start_index;
  logic [DIST_W-1:0]  last_distance;
  logic [COUNT_W-1:0] objects_emitted;

  logic [POS_W:0]     sx, sy, ax, ay;
  logic [DIST_W:0]    dd;
  logic [DIST_W-1:0]  diff;
  logic               last, pt_ok, jump, qualifies;
  logic [IW-1:0]      close_len;
  logic [IW+10:0]     len_ext, minp_ext, start_ext;

  always_comb begin
    sx = {pt.pos_x[POS_W-1], pt.pos_x};
    sy = {pt.pos_y[POS_W-1], pt.pos_y};
    ax = pt.pos_x[POS_W-1] ? ((POS_W+1)'(0) - sx) : sx;
    ay = pt.pos_y[POS_W-1] ? ((POS_W+1)'(0) - sy) : sy;
    pt_ok = (pt.distance >= cfg.dist_floor) &&
            (ax <= {2'b00, cfg.x_limit}) && (ay <= {2'b00, cfg.y_limit});

    dd   = {1'b0, pt.distance} - {1'b0, last_distance};
    diff = dd[DIST_W] ? DIST_W'(~dd[DIST_W-1:0] + 1'b1) : dd[DIST_W-1:0];
    jump = diff >= cfg.gap_threshold;

    last      = pt.is_last || (point_index == LAST_IDX);
    close_len = point_index - start_index;
    len_ext   = {11'b0, close_len};
    minp_ext  = {{IW{1'b0}}, cfg.min_object_points};
    start_ext = {11'b0, start_index};
    qualifies = (len_ext >= minp_ext) && (objects_emitted < cfg.max_objects);

    // an open object ends at the last point, an invalid point or a jump
    res.emit      = tracking && qualifies && (last || !pt_ok || jump);
    res.obj_start = start_ext[OUT_W-1:0];
    res.obj_len   = len_ext[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_index     <= '0;
      tracking        <= 1'b0;
      start_index     <= '0;
      last_distance   <= '0;
      objects_emitted <= '0;
    end else if (step) begin
      if (last) begin
        point_index     <= '0;
        tracking        <= 1'b0;
        start_index     <= '0;
        last_distance   <= '0;
        objects_emitted <= '0;
      end else begin
        point_index <= point_index + 1'b1;
        if (res.emit) begin
          objects_emitted <= objects_emitted + 1'b1;
        end
        if (tracking) begin
          if (!pt_ok) begin
            tracking <= 1'b0;
          end else begin
            // jump point opens the next object
            if (jump) begin
              start_index <= point_index;
            end
            last_distance <= pt.distance;
          end
        end else if (pt_ok) begin
          tracking      <= 1'b1;
          start_index   <= point_index;
          last_distance <= pt.distance;
        end
      end
    end
  end

endmodule

// File: hdl/scan_gap_segmenter.sv
// Top level of the scan gap segmenter: input and result registers around the core.
//
// Points of a range scan enter on the in channel (distance, pos_x, pos_y,
// is_last), one item per cycle at most. Each point lands in an input
// register, from which the segmentation step runs on it and updates the
// scan state. A point that closes a qualifying object loads the result
// register, which shows obj_start and obj_len on the out channel. The
// input and result registers lie between accept and out_valid; sustained
// throughput is one point per cycle while no result is stalled, as the
// step between them is combinational. Points that close nothing produce
// no item. When a result waits with out_ready low, it holds and the input
// register takes one more point; further points wait until it is taken.
// The cfg channel writes the six registers by index and is always ready
// outside reset; write it only while no point is in flight. Synchronous
// reset clears the scan state, both valid flags and all configuration to
// its default values; no in or cfg handshake completes while rst is high.
module scan_gap_segmenter #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sgs_pkg::DIST_W-1:0]     distance,
  input  logic signed [sgs_pkg::POS_W-1:0] pos_x,
  input  logic signed [sgs_pkg::POS_W-1:0] pos_y,
  input  logic                           is_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sgs_pkg::OUT_W-1:0]      obj_start,
  output logic [sgs_pkg::OUT_W-1:0]      obj_len,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sgs_pkg::*;

  cfg_t   cfg;
  point_t pt;
  logic   pt_valid;
  obj_t   res;
  logic   step;

  assign cfg_ready = !rst;
  assign step      = pt_valid && (!out_valid || out_ready);
  assign in_ready  = !rst && (!pt_valid || step);

  sgs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sgs_core #(
    .MAX_POINTS (MAX_POINTS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .pt   (pt),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      pt_valid <= 1'b1;
    end else if (step) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pt.distance <= distance;
      pt.pos_x    <= pos_x;
      pt.pos_y    <= pos_y;
      pt.is_last  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      obj_start <= res.obj_start;
      obj_len   <= res.obj_len;
    end
  end

endmodule

// File: hdl/sgs_checker.sv
// Port-level assertions for the scan gap segmenter, bound to the top level.
module sgs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sgs_pkg::OUT_W-1:0] obj_start,
  input logic [sgs_pkg::OUT_W-1:0] obj_len
);
  import sgs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(obj_start) && $stable(obj_len))
    else $error("result changed while stalled");

  // input side only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // a fresh result comes from a recently taken point that passed the input register
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a recent point");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind scan_gap_segmenter sgs_checker u_sgs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .obj_start (obj_start),
  .obj_len   (obj_len)
);

// File: tb/scan_gap_segmenter_tb.sv
// Testbench for scan_gap_segmenter: random point streams checked against a predicted object list.
`timescale 1ns / 100ps

module scan_gap_segmenter_tb;
  import sgs_pkg::*;

  localparam int MAX_POINTS  = 1024;
  localparam int SETTLE      = 4;     // cycles for a point to clear both registers
  localparam int STALL_LIMIT = 1000;  // cycles with no handshake at all
  localparam int RAND_ITEMS  = 540;

  // Holds the segmentation state and the objects still owed by the block.
  class seg_scoreboard;
    cfg_t              cfg;
    logic [OUT_W-1:0]  next_idx;
    bit                open;
    logic [OUT_W-1:0]  first_idx;
    logic [DIST_W-1:0] prev_dist;
    int                reported;
    obj_t              objects_due[$];
    int                errors;

    function new();
      cfg.dist_floor        = RST_DIST_FLOOR;
      cfg.min_object_points = RST_MIN_OBJECT_POINTS;
      cfg.gap_threshold     = RST_GAP_THRESHOLD;
      cfg.x_limit           = RST_X_LIMIT;
      cfg.y_limit           = RST_Y_LIMIT;
      cfg.max_objects       = RST_MAX_OBJECTS;
      next_idx  = '0;
      open      = 1'b0;
      first_idx = '0;
      prev_dist = '0;
      reported  = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DIST_FLOOR:        cfg.dist_floor        = data[DIST_W-1:0];
        REG_MIN_OBJECT_POINTS: cfg.min_object_points = data[COUNT_W-1:0];
        REG_GAP_THRESHOLD:     cfg.gap_threshold     = data[DIST_W-1:0];
        REG_X_LIMIT:           cfg.x_limit           = data[LIMIT_W-1:0];
        REG_Y_LIMIT:           cfg.y_limit           = data[LIMIT_W-1:0];
        REG_MAX_OBJECTS:       cfg.max_objects       = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // ends the open object just before index stop
    function void close_at(int stop);
      int   len;
      obj_t o;
      len  = stop - int'(first_idx);
      open = 1'b0;
      if (len >= int'(cfg.min_object_points) && reported < int'(cfg.max_objects)) begin
        reported++;
        o.emit      = 1'b1;
        o.obj_start = first_idx;
        o.obj_len   = len[OUT_W-1:0];
        objects_due.push_back(o);
      end
    endfunction

    function void note_point(point_t p);
      int idx, d, ax, ay, diff;
      bit at_end, ok;
      idx = int'(next_idx);
      d   = int'(p.distance);
      ax  = $signed(p.pos_x);
      ay  = $signed(p.pos_y);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      at_end = p.is_last || idx >= MAX_POINTS - 1;
      ok = d >= int'(cfg.dist_floor) && ax <= int'(cfg.x_limit) &&
           ay <= int'(cfg.y_limit);
      if (at_end) begin
        // the closing point never belongs to the object
        if (open) close_at(idx);
        next_idx  = '0;
        open      = 1'b0;
        first_idx = '0;
        prev_dist = '0;
        reported  = 0;
      end else begin
        if (open) begin
          if (!ok) begin
            close_at(idx);
          end else begin
            diff = d - int'(prev_dist);
            if (diff < 0) diff = -diff;
            if (diff >= int'(cfg.gap_threshold)) begin
              close_at(idx);
              open      = 1'b1;
              first_idx = idx[OUT_W-1:0];
            end
            prev_dist = p.distance;
          end
        end else if (ok) begin
          open      = 1'b1;
          first_idx = idx[OUT_W-1:0];
          prev_dist = p.distance;
        end
        next_idx = next_idx + 1'b1;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] start_got, logic [OUT_W-1:0] len_got);
      obj_t want;
      if (objects_due.size() == 0) begin
        errors++;
        $display("%0t: expected no object, got start=%0d len=%0d", $time, start_got, len_got);
        return;
      end
      want = objects_due.pop_front();
      if (start_got !== want.obj_start) begin
        errors++;
        $display("%0t: obj_start expected %0d got %0d", $time, want.obj_start, start_got);
      end
      if (len_got !== want.obj_len) begin
        errors++;
        $display("%0t: obj_len expected %0d got %0d", $time, want.obj_len, len_got);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [DIST_W-1:0]     distance;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                  is_last;
  logic                  out_valid;
  logic                  out_ready;
  logic [OUT_W-1:0]      obj_start;
  logic [OUT_W-1:0]      obj_len;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  seg_scoreboard sb;
  bit            calm;       // no idling on either side while set
  int            hold_cnt = 0;
  int            quiet = 0;
  int            walk_dist;

  scan_gap_segmenter #(.MAX_POINTS(MAX_POINTS)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .distance  (distance),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .is_last   (is_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .obj_start (obj_start),
    .obj_len   (obj_len),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side: check each item, then stall out_ready for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(obj_start, obj_len);
        hold_cnt = calm ? 0 : $urandom_range(0, 5);
        if (hold_cnt != 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (hold_cnt != 0) hold_cnt--;
        if (hold_cnt == 0) out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic point_t pt(int d, int x, int y, bit lst);
    point_t p;
    p.distance = 16'(d);
    p.pos_x    = 16'(x);
    p.pos_y    = 16'(y);
    p.is_last  = lst;
    return p;
  endfunction

  function automatic int pick(int lo_edge, int hi_edge, int lo, int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return lo_edge;
    if (r == 2) return hi_edge;
    return $urandom_range(lo, hi);
  endfunction

  // random walk in distance with jumps, bound hits and some noise
  function automatic point_t make_point();
    point_t p;
    int r, xl, yl, g, step, past;
    xl = int'(sb.cfg.x_limit);
    yl = int'(sb.cfg.y_limit);
    g  = int'(sb.cfg.gap_threshold);
    r  = $urandom_range(0, 99);
    p.is_last = 1'b0;
    if (r < 8) begin
      p.distance = 16'($urandom);
      p.pos_x    = 16'($urandom);
      p.pos_y    = 16'($urandom);
    end else begin
      if (r < 16) step = g + $urandom_range(0, 300);
      else step = $urandom_range(0, g / 2);
      if ($urandom_range(0, 1)) walk_dist += step;
      else walk_dist -= step;
      if (walk_dist > 65535) walk_dist = 65535;
      if (walk_dist < int'(sb.cfg.dist_floor)) walk_dist = int'(sb.cfg.dist_floor);
      p.distance = 16'(walk_dist);
      p.pos_x    = 16'(int'($urandom_range(0, 2 * xl)) - xl);
      p.pos_y    = 16'(int'($urandom_range(0, 2 * yl)) - yl);
      if (r < 24) begin
        // on a bound or one past it
        past = $urandom_range(0, 1);
        if ($urandom_range(0, 1)) p.pos_x = 16'($urandom_range(0, 1) ? xl + past : -(xl + past));
        else p.pos_y = 16'($urandom_range(0, 1) ? yl + past : -(yl + past));
      end
    end
    return p;
  endfunction

  task automatic send_point(point_t p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    distance <= p.distance;
    pos_x    <= p.pos_x;
    pos_y    <= p.pos_y;
    is_last  <= p.is_last;
    do @(posedge clk); while (!in_ready);
    sb.note_point(p);
  endtask

  task automatic send_scan(int n, bit ends);
    point_t p;
    walk_dist = int'(sb.cfg.dist_floor) + $urandom_range(0, 3000);
    for (int i = 0; i < n; i++) begin
      p = make_point();
      if (ends && i == n - 1) p.is_last = 1'b1;
      send_point(p);
    end
  endtask

  // stop sending and wait until every owed object is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.objects_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int gap, kept;
    case (idx)
      REG_MIN_OBJECT_POINTS, REG_MAX_OBJECTS: kept = COUNT_W;
      REG_X_LIMIT, REG_Y_LIMIT:               kept = LIMIT_W;
      default:                                kept = CFG_DATA_W;
    endcase
    // junk in the bits above the register width
    if (kept < CFG_DATA_W && $urandom_range(0, 1)) data = data | (16'($urandom) << kept);
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic program_cfg(int md, int mo, int gt, int xl, int yl, int mx);
    drain();
    cfg_write(REG_DIST_FLOOR, 16'(md));
    cfg_write(REG_MIN_OBJECT_POINTS, 16'(mo));
    cfg_write(REG_GAP_THRESHOLD, 16'(gt));
    cfg_write(REG_X_LIMIT, 16'(xl));
    cfg_write(REG_Y_LIMIT, 16'(yl));
    cfg_write(REG_MAX_OBJECTS, 16'(mx));
    if ($urandom_range(0, 1))
      cfg_write(CFG_IDX_W'(REG_MAX_OBJECTS + 1 + $urandom_range(0, 1)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int rand_items, n;
    sb        = new();
    calm      = 1'b0;
    walk_dist = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    distance  = '0;
    pos_x     = '0;
    pos_y     = '0;
    is_last   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: gap 90, |x| <= 1300, |y| <= 800
    send_point(pt(1000, 0, 0, 0));
    send_point(pt(1050, 5, -5, 0));
    send_point(pt(1140, 0, 0, 0));        // jump of exactly the gap
    send_point(pt(1140, 1301, 0, 0));     // x one past the bound
    send_point(pt(1140, -1300, 800, 0));  // both on the bound
    send_point(pt(1140, 0, -801, 0));
    send_point(pt(65535, -32768, 0, 0));
    send_point(pt(0, 32767, 32767, 0));
    send_point(pt(0, 0, 0, 0));
    send_point(pt(65535, 0, 0, 0));
    send_point(pt(65535, 0, 0, 0));
    send_point(pt(65535, 0, 0, 1));       // last point closes the object without itself
    send_point(pt(500, 0, 0, 1));         // scan of a single point
    send_point(pt(500, 0, 0, 0));
    send_point(pt(5000, 0, 0, 1));        // jump on the last point
    send_point(pt(500, 0, 0, 0));
    send_point(pt(500, 2000, 0, 1));      // invalid last point

    // zero gap: every point of an open object starts a new one
    program_cfg(0, 1, 0, 1300, 800, 16);
    repeat (4) send_point(pt(700, 0, 0, 0));
    send_point(pt(700, 0, 0, 1));

    program_cfg(0, 0, 0, 0, 0, 0);
    repeat (3) send_scan($urandom_range(1, 30), 1'b1);
    program_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) send_scan($urandom_range(1, 30), 1'b1);
    program_cfg(0, 0, 1, 32767, 32767, 1024);
    repeat (3) send_scan($urandom_range(1, 40), 1'b1);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      program_cfg(pick(0, 65535, 0, 400), pick(0, 1024, 1, 4), pick(0, 65535, 1, 500),
                  pick(0, 32767, 200, 3000), pick(0, 32767, 200, 3000),
                  pick(0, 1024, 1, 8));
      repeat ($urandom_range(2, 5)) begin
        n = $urandom_range(1, 60);
        send_scan(n, 1'b1);
        rand_items += n;
        if ($urandom_range(0, 4) == 0) drain();
      end
    end

    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.objects_due.size() == 0) begin
      $display("status: pass");
    end else begin
      if (sb.objects_due.size() != 0)
        $display("%0t: %0d objects never came out", $time, sb.objects_due.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
